/* design/int_to_decimal_ascii_macros.svh */
// Assertion macros for the back end, the only design file that includes them.
// With SYNTH defined the macros expand to nothing.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define IDA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define IDA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define IDA_ASSERT_NOW(label, ante, cons)
`define IDA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* design/ida_pkg.sv */
package ida_pkg;

    // Number of decimal digit slots; higher digits beyond this are dropped.
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // floor(m * RECIP10 / 2**RECIP_SHIFT) equals m / 10 for every 32-bit m.
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } ida_entry_t;

    typedef struct packed {
        logic       valid;
        ida_entry_t entry;
    } ida_qside_t;

endpackage

/* design/ida_front.sv */
module ida_front
    import ida_pkg::*;
(
    input  logic signed [31:0] value,
    output ida_entry_t         entry
);

    // The magnitude is formed as an unsigned value, so the most negative
    // number maps to 0x80000000 without overflow.
    always_comb
    begin
        entry.neg = value[31];
        entry.mag = value[31] ? (~value + 32'd1) : value;
    end

endmodule

/* design/ida_queue.sv */
module ida_queue
    import ida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  ida_entry_t wr_entry,
    output logic       full,
    input  logic       rd_en,
    output ida_qside_t rd_side
);

    ida_entry_t         slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_wr, do_rd;

    assign full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && (cnt_reg != '0);

    assign rd_side.valid = (cnt_reg != '0);
    assign rd_side.entry = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

/* design/ida_back.sv */
`include "int_to_decimal_ascii_macros.svh"

module ida_back
    import ida_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ida_qside_t q_side,
    output logic       q_pop,
    output logic [7:0] ascii_char,
    output logic       last,
    output logic       empty,
    input  logic       pop
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUB  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [31:0]       mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [63:0]       prod_reg, prod_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              sign_pend_reg, sign_pend_next;
    logic [3:0]        digits_reg [MAX_DIGITS];
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              out_load;
    logic              dig_we;
    logic [QUOT_W-1:0] quotient;
    logic [31:0]       quot32;
    logic [31:0]       rem32;
    logic [3:0]        digit;
    logic [CNT_W-1:0]  cnt_inc;

    assign out_free = !out_valid_reg || pop;
    assign quotient = prod_reg[63:RECIP_SHIFT];
    assign quot32   = 32'(quotient);
    // Remainder is m - 10q, with 10q built from two shifts.
    assign rem32    = mag_reg - (quot32 << 3) - (quot32 << 1);
    assign digit    = rem32[3:0];
    assign cnt_inc  = cnt_reg + 1'b1;

    assign q_pop      = (state_reg == ST_IDLE) && q_side.valid;
    assign empty      = !out_valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        sign_pend_next = sign_pend_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        dig_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_side.valid)
                begin
                    mag_next   = q_side.entry.mag;
                    neg_next   = q_side.entry.neg;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = 64'(mag_reg) * 64'(RECIP10);
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                dig_we   = 1'b1;
                mag_next = quot32;
                cnt_next = cnt_inc;
                if ((quotient == '0) || (cnt_inc == CNT_W'(MAX_DIGITS)))
                begin
                    idx_next       = cnt_reg[IDX_W-1:0];
                    sign_pend_next = neg_reg;
                    state_next     = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (sign_pend_reg)
                    begin
                        char_next      = CHAR_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next = CHAR_ZERO + {4'b0000, digits_reg[idx_reg]};
                        last_next = (idx_reg == '0);
                        if (idx_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        if (dig_we)
        begin
            digits_reg[cnt_reg[IDX_W-1:0]] <= digit;
        end
    end

    // The digit count stays within the slots while characters are sent.
    `IDA_ASSERT_NOW(a_cnt_range, state_reg == ST_EMIT,
        (cnt_reg != '0) && (cnt_reg <= CNT_W'(MAX_DIGITS)))
    // Every character shown is a minus sign or a decimal digit.
    `IDA_ASSERT_NOW(a_char_legal, out_valid_reg,
        (char_reg == CHAR_MINUS) ||
        ((char_reg >= CHAR_ZERO) && (char_reg <= CHAR_ZERO + 8'd9)))
    // A fresh number starts its conversion right after it leaves the queue.
    `IDA_ASSERT_NEXT(a_pop_starts, q_pop, (state_reg == ST_MUL) && (cnt_reg == '0))
    // The minus sign is never flagged as the final character.
    `IDA_ASSERT_NOW(a_minus_not_last, out_valid_reg && (char_reg == CHAR_MINUS), !last_reg)

endmodule

/* design/int_to_decimal_ascii.sv */
// Channel   Direction  Handshake        Payload
// input     in         push / full      value[31:0] signed
// result    out        pop / empty      ascii_char[7:0], last
//
// A number leaves the queue in the idle state between numbers; each of
// its digits then takes a multiply by the reciprocal of ten, then the
// quotient and remainder step, and its text leaves one character per cycle
// while pop keeps up, with a minus sign first for a negative number.
// Reset is asynchronous and active low and empties the queue and the output.
// A stalled output holds its character, and full rises once both queue entries wait.

module int_to_decimal_ascii
    import ida_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] value,
    input  logic               pop,
    output logic               empty,
    output logic [7:0]         ascii_char,
    output logic               last
);

    // Sign and unsigned magnitude of the incoming number.
    ida_entry_t front_entry;

    // Head of the queue as seen by the back end, and its dequeue request.
    ida_qside_t q_side;
    logic       q_pop;

    // The front end classifies each number as it arrives.
    ida_front u_front (
        .value (value),
        .entry (front_entry)
    );

    // A short queue decouples accepting numbers from converting them.
    ida_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_entry (front_entry),
        .full     (full),
        .rd_en    (q_pop),
        .rd_side  (q_side)
    );

    // The back end extracts digits least significant first into its digit
    // store, then sends them most significant first through an output register.
    ida_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_side     (q_side),
        .q_pop      (q_pop),
        .ascii_char (ascii_char),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

/* test/tb_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

// Testbench for the signed integer to decimal text converter.
//
// Each request on the input side carries one 32-bit signed number. The block
// answers with the decimal text of that number, one ASCII character per
// request on the result side, most significant first, with last set on the
// final character. The bench computes the same text on its own for every
// accepted number and keeps the characters in order. Every character that
// leaves the block is checked against the oldest one still waiting.

module tb_int_to_decimal_ascii;

    import ida_pkg::*;

    localparam logic [31:0] DEC_BASE = 32'd10;

    // The run is ended by force well past any correct finish.
    localparam int CYCLE_LIMIT = 200000;

    // Worst case work for one number is the digit steps for ten digits,
    // eleven characters and a return to idle, so this covers a late result.
    localparam int SETTLE_CYCLES = 40;

    localparam int RANDOM_NUMBERS = 220;

    // The receiver stops popping for a long stretch once this many characters
    // have been taken, so the input side must fill and raise full.
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic signed [31:0] value = '0;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    logic [7:0]         ascii_char;
    logic               last;

    // Numbers not yet accepted by the block; the front one is on the port
    // whenever push is high.
    logic signed [31:0] numbers_to_send[$];

    // Characters the block still owes, oldest first.
    text_char_t pending_chars[$];

    int error_count = 0;
    int cycle_count = 0;

    int burst_left = 0;
    int gap_left = 0;

    int       chars_seen = 0;
    int       hold_left = 0;
    logic     hold_done = 1'b0;
    logic [7:0] stall_mask = 8'hFF;
    int       mask_age = 0;

    int_to_decimal_ascii dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .pop        (pop),
        .empty      (empty),
        .ascii_char (ascii_char),
        .last       (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Turns one number into the characters the block must emit for it. The
    // magnitude is formed in unsigned 32-bit arithmetic, so the most negative
    // number needs no special path. Digits beyond the slot count are dropped
    // from the top, just as the block keeps only its lowest digits.
    task automatic expand_decimal_text(input logic signed [31:0] num);
        logic [31:0] mag;
        logic        neg;
        logic [3:0]  digits[MAX_DIGITS];
        int          count;
        text_char_t  c;

        neg = num[31];
        mag = num;
        if (neg)
            mag = ~mag + 32'd1;

        count = 0;
        do
        begin
            digits[count] = 4'(mag % DEC_BASE);
            count++;
            mag = mag / DEC_BASE;
        end
        while (mag != 0 && count < MAX_DIGITS);

        if (neg)
        begin
            c.ch  = CHAR_MINUS;
            c.fin = 1'b0;
            pending_chars.push_back(c);
        end

        for (int i = count - 1; i >= 0; i--)
        begin
            c.ch  = CHAR_ZERO + {4'd0, digits[i]};
            c.fin = (i == 0);
            pending_chars.push_back(c);
        end
    endtask

    // Sender. A request is accepted at an edge where push is high and full is
    // low; the bench then predicts the text of the number that was on the
    // port. An offer that meets full stays up unchanged. Otherwise the next
    // number goes out unless the sender is in one of its gaps. Bursts have a
    // random length and are followed by a random gap, often none at all.
    always @(posedge clk)
    begin
        logic next_push;
        logic holding;

        if (rst_n)
        begin
            holding   = push && full;
            next_push = holding;

            if (push && !full)
            begin
                expand_decimal_text(value);
                void'(numbers_to_send.pop_front());
            end

            if (!holding)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else if (numbers_to_send.size() != 0)
                begin
                    next_push = 1'b1;
                    value <= numbers_to_send[0];
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end

            push <= next_push;
        end
    end

    // Receiver. A character is taken at an edge where pop is high and empty
    // is low, and it is checked against the oldest prediction. Pop follows a
    // rotating eight-bit mask that is redrawn after each full turn, sometimes
    // as all ones so that long runs without stalls occur. Once, after enough
    // characters, the receiver holds off entirely for a long stretch.
    always @(posedge clk)
    begin
        text_char_t want;
        logic       next_pop;

        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character: ascii_char %h, last %b", ascii_char, last);
                    error_count++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (ascii_char !== want.ch)
                    begin
                        $error("ascii_char: expected %h, got %h", want.ch, ascii_char);
                        error_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %b, got %b", want.fin, last);
                        error_count++;
                    end
                end
                chars_seen++;
            end

            if (hold_left != 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else if (!hold_done && chars_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                next_pop  = 1'b0;
            end
            else
            begin
                if (mask_age == 0)
                begin
                    stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
                    if (stall_mask == 8'h00)
                        stall_mask = 8'h81;
                    mask_age = 8;
                end
                next_pop   = stall_mask[0];
                stall_mask = {stall_mask[0], stall_mask[7:1]};
                mask_age--;
            end

            pop <= next_pop;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        longint lo;
        longint hi;
        longint pick;
        int     digits;
        int     kind;

        // Directed numbers: zero, the smallest and largest values, the most
        // negative value that cannot be negated in 32 bits, several digit count
        // boundaries, and alternating bit patterns.
        numbers_to_send.push_back(32'sd0);
        numbers_to_send.push_back(32'sd1);
        numbers_to_send.push_back(-32'sd1);
        numbers_to_send.push_back(32'sd9);
        numbers_to_send.push_back(32'sd10);
        numbers_to_send.push_back(-32'sd10);
        numbers_to_send.push_back(32'sd99);
        numbers_to_send.push_back(32'sd100);
        numbers_to_send.push_back(-32'sd5);
        numbers_to_send.push_back(32'sh7FFF_FFFF);
        numbers_to_send.push_back(32'sh8000_0000);
        numbers_to_send.push_back(32'sh8000_0001);
        numbers_to_send.push_back(32'sd999999999);
        numbers_to_send.push_back(32'sd1000000000);
        numbers_to_send.push_back(-32'sd999999999);
        numbers_to_send.push_back(-32'sd1000000000);
        numbers_to_send.push_back(32'sd1234567890);
        numbers_to_send.push_back(-32'sd1234567890);
        numbers_to_send.push_back(32'sh5555_5555);
        numbers_to_send.push_back(32'shAAAA_AAAA);
        numbers_to_send.push_back(32'sd0);

        // Random numbers: raw 32-bit patterns, small values, values of a
        // chosen digit count, and values near the ends of the range.
        for (int n = 0; n < RANDOM_NUMBERS; n++)
        begin
            kind = $urandom_range(0, 3);
            case (kind)
                0: pick = longint'($signed($urandom));
                1: pick = $urandom_range(0, 99);
                2:
                begin
                    digits = $urandom_range(1, 10);
                    lo = 1;
                    repeat (digits - 1)
                        lo = lo * 10;
                    hi = lo * 10 - 1;
                    if (hi > 64'sd2147483647)
                        hi = 64'sd2147483647;
                    pick = lo + (longint'($urandom) % (hi - lo + 1));
                end
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        pick = 64'sd2147483647 - $urandom_range(0, 20);
                    else
                        pick = -64'sd2147483648 + $urandom_range(0, 20);
                end
            endcase
            if (kind != 0 && kind != 3 && $urandom_range(0, 1) == 1)
                pick = -pick;
            numbers_to_send.push_back(32'(pick));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every number has been accepted, then until every
        // predicted character has come out, then a little longer so that a
        // stray extra character would still be caught.
        while (numbers_to_send.size() != 0 || push)
            @(negedge clk);
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (pending_chars.size() != 0)
        begin
            $error("%0d predicted characters never arrived", pending_chars.size());
            error_count++;
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/ida_pkg.sv
design/ida_front.sv
design/ida_queue.sv
design/ida_back.sv
design/int_to_decimal_ascii.sv
test/tb_int_to_decimal_ascii.sv
